// ----- rtl/tcw_pkg.sv -----
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, command and status types for the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLUMNS   = 80;
  localparam int ROWS      = 25;
  localparam int CELLS     = COLUMNS * ROWS;
  localparam int CW        = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int RW        = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int AW        = $clog2(CELLS + 1);
  localparam int COPY_LAST = COLUMNS * (ROWS - 1) - 1;

  localparam logic [15:0] BLANK_CELL   = 16'h0720;
  localparam logic [7:0]  ATTR_BITS    = 8'h07;
  localparam logic [7:0]  NEWLINE_CODE = 8'd10;
  localparam logic        ACTION_CLEAR = 1'b1;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_CLEAR,
    ST_SCR_RD,
    ST_SCR_WR,
    ST_BLANK_ROW,
    ST_RESP
  } state_e;

  typedef enum logic [1:0] {
    ADDR_HOLD,
    ADDR_ZERO,
    ADDR_INC
  } addr_op_e;

  typedef enum logic [2:0] {
    MEM_NONE,
    MEM_PUT,
    MEM_READ_NEXT,
    MEM_COPY,
    MEM_BLANK
  } mem_op_e;

  typedef enum logic [1:0] {
    CUR_HOLD,
    CUR_HOME,
    CUR_ADVANCE,
    CUR_NEWLINE
  } cur_op_e;

  typedef struct packed {
    logic     capture;
    logic     set_scrolled;
    addr_op_e addr_op;
    mem_op_e  mem_op;
    cur_op_e  cur_op;
  } cmd_t;

  typedef struct packed {
    logic is_clear;
    logic is_newline;
    logic col_last;
    logic row_last;
    logic copy_end;
    logic cell_end;
  } status_t;

endpackage

// ----- rtl/tcw_ctrl.sv -----
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer for put, newline, scroll, clear and the power-up blanking pass.
// ----------------------------------------------------------------------------
module tcw_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  tcw_pkg::status_t status_i,
  output tcw_pkg::cmd_t    cmd_o
);

  tcw_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tcw_pkg::ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tcw_pkg::ST_INIT: begin
        if (status_i.cell_end) state_d = tcw_pkg::ST_IDLE;
      end
      tcw_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = tcw_pkg::ST_DECODE;
      end
      tcw_pkg::ST_DECODE: begin
        if (status_i.is_clear) begin
          state_d = tcw_pkg::ST_CLEAR;
        end else if ((status_i.is_newline || status_i.col_last) && status_i.row_last) begin
          state_d = tcw_pkg::ST_SCR_RD;
        end else begin
          state_d = tcw_pkg::ST_RESP;
        end
      end
      tcw_pkg::ST_CLEAR: begin
        if (status_i.cell_end) state_d = tcw_pkg::ST_RESP;
      end
      tcw_pkg::ST_SCR_RD: begin
        state_d = tcw_pkg::ST_SCR_WR;
      end
      tcw_pkg::ST_SCR_WR: begin
        state_d = status_i.copy_end ? tcw_pkg::ST_BLANK_ROW : tcw_pkg::ST_SCR_RD;
      end
      tcw_pkg::ST_BLANK_ROW: begin
        if (status_i.cell_end) state_d = tcw_pkg::ST_RESP;
      end
      tcw_pkg::ST_RESP: begin
        if (out_ready_i) state_d = tcw_pkg::ST_IDLE;
      end
      default: state_d = tcw_pkg::ST_INIT;
    endcase
  end

  always_comb begin
    cmd_o       = '{capture: 1'b0, set_scrolled: 1'b0, addr_op: tcw_pkg::ADDR_HOLD,
                    mem_op: tcw_pkg::MEM_NONE, cur_op: tcw_pkg::CUR_HOLD};
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      tcw_pkg::ST_INIT, tcw_pkg::ST_CLEAR, tcw_pkg::ST_BLANK_ROW: begin
        cmd_o.mem_op  = tcw_pkg::MEM_BLANK;
        cmd_o.addr_op = tcw_pkg::ADDR_INC;
      end
      tcw_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      tcw_pkg::ST_DECODE: begin
        if (status_i.is_clear) begin
          cmd_o.addr_op = tcw_pkg::ADDR_ZERO;
          cmd_o.cur_op  = tcw_pkg::CUR_HOME;
        end else begin
          if (!status_i.is_newline) cmd_o.mem_op = tcw_pkg::MEM_PUT;
          if (status_i.is_newline || status_i.col_last) begin
            cmd_o.cur_op = tcw_pkg::CUR_NEWLINE;
            if (status_i.row_last) begin
              cmd_o.set_scrolled = 1'b1;
              cmd_o.addr_op      = tcw_pkg::ADDR_ZERO;
            end
          end else begin
            cmd_o.cur_op = tcw_pkg::CUR_ADVANCE;
          end
        end
      end
      tcw_pkg::ST_SCR_RD: begin
        cmd_o.mem_op = tcw_pkg::MEM_READ_NEXT;
      end
      tcw_pkg::ST_SCR_WR: begin
        cmd_o.mem_op  = tcw_pkg::MEM_COPY;
        cmd_o.addr_op = tcw_pkg::ADDR_INC;
      end
      tcw_pkg::ST_RESP: begin
        out_valid_o = 1'b1;
      end
      default: begin
        cmd_o.mem_op = tcw_pkg::MEM_NONE;
      end
    endcase
  end

endmodule

// ----- rtl/tcw_datapath.sv -----
// ----------------------------------------------------------------------------
// tcw_datapath
// Cursor registers, sweep address counter and the single-port screen memory.
// ----------------------------------------------------------------------------
module tcw_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tcw_pkg::cmd_t         cmd_i,
  output tcw_pkg::status_t      status_o,
  input  logic                  action_i,
  input  logic [7:0]            char_code_i,
  output logic [tcw_pkg::CW-1:0] col_o,
  output logic [tcw_pkg::RW-1:0] row_o,
  output logic                  scrolled_o
);

  localparam int AW = tcw_pkg::AW;
  localparam int CW = tcw_pkg::CW;
  localparam int RW = tcw_pkg::RW;

  logic          action_q;
  logic [7:0]    code_q;
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic          scrolled_q;
  logic [AW-1:0] addr_q, addr_d;

  logic [15:0]   mem [tcw_pkg::CELLS];
  logic [15:0]   rd_q;
  logic          we, re;
  logic [AW-1:0] wa, ra, put_idx;
  logic [15:0]   wd;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      action_q <= action_i;
      code_q   <= char_code_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      scrolled_q <= 1'b0;
      addr_q     <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      addr_q <= addr_d;
      if (cmd_i.capture) begin
        scrolled_q <= 1'b0;
      end else if (cmd_i.set_scrolled) begin
        scrolled_q <= 1'b1;
      end
    end
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    unique case (cmd_i.cur_op)
      tcw_pkg::CUR_HOLD: ;
      tcw_pkg::CUR_HOME: begin
        col_d = '0;
        row_d = '0;
      end
      tcw_pkg::CUR_ADVANCE: col_d = col_q + CW'(1);
      tcw_pkg::CUR_NEWLINE: begin
        col_d = '0;
        if (!status_o.row_last) row_d = row_q + RW'(1);
      end
      default: ;
    endcase
  end

  always_comb begin
    unique case (cmd_i.addr_op)
      tcw_pkg::ADDR_HOLD: addr_d = addr_q;
      tcw_pkg::ADDR_ZERO: addr_d = '0;
      tcw_pkg::ADDR_INC:  addr_d = addr_q + AW'(1);
      default:            addr_d = addr_q;
    endcase
  end

  assign put_idx = AW'(32'(row_q) * tcw_pkg::COLUMNS + 32'(col_q));
  assign ra      = addr_q + AW'(tcw_pkg::COLUMNS);

  always_comb begin
    we = 1'b0;
    re = 1'b0;
    wa = addr_q;
    wd = tcw_pkg::BLANK_CELL;
    unique case (cmd_i.mem_op)
      tcw_pkg::MEM_NONE: ;
      tcw_pkg::MEM_PUT: begin
        we = 1'b1;
        wa = put_idx;
        wd = {tcw_pkg::ATTR_BITS, code_q};
      end
      tcw_pkg::MEM_READ_NEXT: re = 1'b1;
      tcw_pkg::MEM_COPY: begin
        we = 1'b1;
        wd = rd_q;
      end
      tcw_pkg::MEM_BLANK: we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    if (re) rd_q <= mem[ra];
  end

  assign status_o.is_clear   = (action_q == tcw_pkg::ACTION_CLEAR);
  assign status_o.is_newline = (code_q == tcw_pkg::NEWLINE_CODE);
  assign status_o.col_last   = (32'(col_q) == tcw_pkg::COLUMNS - 1);
  assign status_o.row_last   = (32'(row_q) == tcw_pkg::ROWS - 1);
  assign status_o.copy_end   = (32'(addr_q) == tcw_pkg::COPY_LAST);
  assign status_o.cell_end   = (32'(addr_q) == tcw_pkg::CELLS - 1);

  assign col_o      = col_q;
  assign row_o      = row_q;
  assign scrolled_o = scrolled_q;

`ifndef SYNTH
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(col_q) < tcw_pkg::COLUMNS) else $error("cursor column out of range");
  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(row_q) < tcw_pkg::ROWS) else $error("cursor row out of range");
  a_write_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> 32'(wa) < tcw_pkg::CELLS) else $error("memory write out of range");
  a_scroll_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.set_scrolled |=> 32'(row_q) == tcw_pkg::ROWS - 1)
    else $error("scroll left the cursor off the last row");
`endif

endmodule

// ----- rtl/text_console_writer.sv -----
// ----------------------------------------------------------------------------
// text_console_writer
// Text console with a cursor, one-row scroll and full-screen clear.
// ----------------------------------------------------------------------------
// Each transfer on the input channel gives exactly one transfer on the output
// channel carrying the cursor position after the item and a scroll flag. The
// screen lives in a single-port memory, so every sweep makes one memory
// access at a time. A plain character or a newline is taken in the idle
// state, decoded in the decode state and answered from the response state.
// A scroll walks the row copy (a read and a write per cell) and then blanks
// the bottom row. A clear blanks every cell. After reset the block blanks
// the screen before it takes its first input. One item is worked on at a
// time.
module text_console_writer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       action_i,
  input  logic [7:0] char_code_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [6:0] cursor_col_o,
  output logic [4:0] cursor_row_o,
  output logic       scrolled_o
);

  tcw_pkg::cmd_t           cmd;
  tcw_pkg::status_t        status;
  logic [tcw_pkg::CW-1:0] col;
  logic [tcw_pkg::RW-1:0] row;

  tcw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tcw_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .action_i    (action_i),
    .char_code_i (char_code_i),
    .col_o       (col),
    .row_o       (row),
    .scrolled_o  (scrolled_o)
  );

  assign cursor_col_o = 7'(col);
  assign cursor_row_o = 5'(row);

endmodule

// ----- verif/text_console_writer_tb.sv -----
// ----------------------------------------------------------------------------
// text_console_writer_tb
// Self-checking testbench for the text console writer.
// ----------------------------------------------------------------------------
// Characters, newlines and clears are sent on the input channel in bursts with
// random gaps. A shadow copy of the screen and cursor predicts the cursor
// position and scroll flag of every result. Results are taken by a receiver
// that stalls in changing patterns. The tests cover byte extremes, control
// bytes, clears, scrolling by newline and by wrap on the bottom row, random
// lines of text, and a long receiver hold-off that fills the block.
// ----------------------------------------------------------------------------
module text_console_writer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [6:0] col;
    logic [4:0] row;
    logic       scrolled;
  } cursor_report_t;

  typedef enum int {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE
  } rx_mode_e;

  localparam int RX_HOLD_CYCLES = 1000;
  localparam int DRAIN_CYCLES   = 4000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_action = 1'b0;
  logic [7:0] in_char = 8'h00;
  logic       out_ready = 1'b0;
  logic       hold_req = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic [6:0] cursor_col;
  logic [4:0] cursor_row;
  logic       scrolled;

  cursor_report_t pending_reports[$];
  int             mismatch_count = 0;
  int             burst_left = 0;
  logic           gaps_off = 1'b0;

  logic [15:0] shadow_screen [tcw_pkg::CELLS];
  logic [6:0]  shadow_col;
  logic [4:0]  shadow_row;

  text_console_writer u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .action_i     (in_action),
    .char_code_i  (in_char),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .cursor_col_o (cursor_col),
    .cursor_row_o (cursor_row),
    .scrolled_o   (scrolled)
  );

  always #5 clk = ~clk;

  function automatic logic shadow_line_break();
    shadow_col = '0;
    if (shadow_row < tcw_pkg::ROWS - 1) begin
      shadow_row++;
      return 1'b0;
    end
    for (int i = 0; i < tcw_pkg::COLUMNS * (tcw_pkg::ROWS - 1); i++) begin
      shadow_screen[i] = shadow_screen[i + tcw_pkg::COLUMNS];
    end
    for (int i = tcw_pkg::COLUMNS * (tcw_pkg::ROWS - 1); i < tcw_pkg::CELLS; i++) begin
      shadow_screen[i] = tcw_pkg::BLANK_CELL;
    end
    return 1'b1;
  endfunction

  function automatic cursor_report_t shadow_apply(logic act, logic [7:0] code);
    cursor_report_t rep;
    logic           scr;
    scr = 1'b0;
    if (act == tcw_pkg::ACTION_CLEAR) begin
      foreach (shadow_screen[i]) shadow_screen[i] = tcw_pkg::BLANK_CELL;
      shadow_col = '0;
      shadow_row = '0;
    end else if (code == tcw_pkg::NEWLINE_CODE) begin
      scr = shadow_line_break();
    end else begin
      shadow_screen[shadow_row * tcw_pkg::COLUMNS + shadow_col] = {tcw_pkg::ATTR_BITS, code};
      shadow_col++;
      if (shadow_col >= tcw_pkg::COLUMNS) begin
        scr = shadow_line_break();
      end
    end
    rep.col      = shadow_col;
    rep.row      = shadow_row;
    rep.scrolled = scr;
    return rep;
  endfunction

  function automatic logic [7:0] any_glyph();
    logic [7:0] code;
    code = 8'($urandom_range(0, 255));
    if (code == tcw_pkg::NEWLINE_CODE) code = 8'h0B;
    return code;
  endfunction

  task automatic put_on_console(input logic act, input logic [7:0] code);
    int gap;
    gap = 0;
    if (!gaps_off) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      end
      burst_left--;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_action <= act;
    in_char   <= code;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_reports.push_back(shadow_apply(act, code));
  endtask

  task automatic put_char(input logic [7:0] code);
    put_on_console(1'b0, code);
  endtask

  task automatic wipe_console(input logic [7:0] code);
    put_on_console(tcw_pkg::ACTION_CLEAR, code);
  endtask

  task automatic test_directed();
    put_char(8'h00);
    put_char(8'hFF);
    put_char(8'h80);
    put_char(8'h7F);
    put_char(8'h09);
    put_char(8'h0D);
    put_char(8'h01);
    put_char(tcw_pkg::NEWLINE_CODE);
    put_char(tcw_pkg::NEWLINE_CODE);
    put_char(8'h41);
    wipe_console(8'hFF);
    wipe_console(8'h00);
    wipe_console(tcw_pkg::NEWLINE_CODE);
    put_char(tcw_pkg::NEWLINE_CODE);
    put_char(8'h20);
    put_char(8'h55);
    put_char(8'hAA);
    put_char(8'h0B);
    wipe_console(8'h5A);
  endtask

  task automatic test_bottom_edge();
    wipe_console(8'hA5);
    repeat (tcw_pkg::ROWS - 1) put_char(tcw_pkg::NEWLINE_CODE);
    put_char(tcw_pkg::NEWLINE_CODE);
    repeat (tcw_pkg::COLUMNS - 1) put_char(any_glyph());
    put_char(any_glyph());
    repeat (4) put_char(any_glyph());
    put_char(tcw_pkg::NEWLINE_CODE);
  endtask

  task automatic test_random();
    int sent;
    int len;
    sent = 0;
    while (sent < 16) begin
      if ($urandom_range(0, 19) == 0) begin
        wipe_console(8'($urandom_range(0, 255)));
        sent++;
      end else begin
        len = $urandom_range(0, 10);
        repeat (len) begin
          if ($urandom_range(0, 15) == 0) put_char(8'($urandom_range(0, 255)));
          else put_char(any_glyph());
        end
        put_char(tcw_pkg::NEWLINE_CODE);
        sent += len + 1;
      end
    end
  endtask

  task automatic test_backpressure();
    in_valid <= 1'b0;
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    gaps_off = 1'b1;
    repeat (8) put_char(any_glyph());
    gaps_off = 1'b0;
  endtask

  always @(posedge clk) begin : receiver
    int       hold_left;
    int       phase_left;
    rx_mode_e rx_mode;
    if (hold_req) hold_left = RX_HOLD_CYCLES;
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(1, 64);
        rx_mode = rx_mode_e'($urandom_range(0, 2));
      end
      phase_left--;
      case (rx_mode)
        RX_OPEN: out_ready <= 1'b1;
        RX_COIN: out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin : result_check
    cursor_report_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual col=%0d row=%0d scrolled=%0d",
                 $time, cursor_col, cursor_row, scrolled);
        mismatch_count++;
      end else begin
        want = pending_reports.pop_front();
        if (cursor_col !== want.col) begin
          $display("%0t: cursor_col mismatch: expected %0d, actual %0d",
                   $time, want.col, cursor_col);
          mismatch_count++;
        end
        if (cursor_row !== want.row) begin
          $display("%0t: cursor_row mismatch: expected %0d, actual %0d",
                   $time, want.row, cursor_row);
          mismatch_count++;
        end
        if (scrolled !== want.scrolled) begin
          $display("%0t: scrolled mismatch: expected %0d, actual %0d",
                   $time, want.scrolled, scrolled);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    foreach (shadow_screen[i]) shadow_screen[i] = tcw_pkg::BLANK_CELL;
    shadow_col = '0;
    shadow_row = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_bottom_edge();
    test_random();
    test_backpressure();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("%0t: timeout with %0d results outstanding", $time, pending_reports.size());
    $display("status: fail");
    $finish;
  end

endmodule
